FILE: sv/bipartite_max_matching_top_defines.svh
// Assertion macros used by the port-level checker of the matching engine.
`ifndef BIPARTITE_MAX_MATCHING_TOP_DEFINES_SVH
`define BIPARTITE_MAX_MATCHING_TOP_DEFINES_SVH

// Implication in the same cycle, ignored while reset is high.
`define BMM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication into the next cycle, ignored while reset is high.
`define BMM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Implication into the next cycle, checked during reset as well.
`define BMM_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: sv/bmm_pkg.sv
// Shared constants of the maximum bipartite matching engine.
`timescale 1ns / 1ps
package bmm_pkg;
  localparam int VTX_W = 6;
  localparam int PART_W = 7;
  localparam int CFG_W = 7;
  localparam int LAYER_W = 8;
  localparam int DEF_MAX_VERTICES = 64;
  localparam int DEF_MAX_EDGES = 512;
  localparam logic [PART_W-1:0] UNMATCHED = 7'd64;
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;
  localparam logic REQ_ADD = 1'b0;
  localparam logic REQ_RUN = 1'b1;
endpackage

FILE: sv/bmm_if.sv
// Request and result channel interfaces of the matching engine.
`timescale 1ns / 1ps
interface bmm_req_if;
  import bmm_pkg::*;
  logic valid;
  logic ready;
  logic req_type;
  logic [VTX_W-1:0] left_vertex;
  logic [VTX_W-1:0] right_vertex;
  modport source (output valid, req_type, left_vertex, right_vertex, input ready);
  modport sink (input valid, req_type, left_vertex, right_vertex, output ready);
endinterface

interface bmm_res_if;
  import bmm_pkg::*;
  logic valid;
  logic ready;
  logic [VTX_W-1:0] left_index;
  logic [PART_W-1:0] partner;
  logic [PART_W-1:0] match_count;
  logic edges_dropped;
  logic last;
  modport source (output valid, left_index, partner, match_count, edges_dropped, last,
                  input ready);
  modport sink (input valid, left_index, partner, match_count, edges_dropped, last,
                output ready);
endinterface

FILE: sv/bipartite_max_matching_top.sv
// Top level of the Hopcroft-Karp maximum bipartite matching engine.
// An edge item reads the head of the left vertex's edge list and then links the new edge in
// front of it. A run item computes the matching from scratch and then delivers one result item
// per left vertex, each read from the partner memory and then registered when the result slot
// is free. The run time is set by the graph walk through the edge memory, since every step waits
// on one registered memory read. Each breadth-first phase seeds the queue with the free left
// vertices, then takes vertices from the queue and visits their edges, layering each right
// vertex seen for the first time and queueing the partner of a matched one. Each depth-first
// search tries edges, descends to the partner of a matched right vertex on the next layer,
// backtracks when an edge list runs out and writes the vertex pairs back along a found path.
// At most MAX_VERTICES+1 phases are run. Right vertices out of range are skipped during the walk.
`timescale 1ns / 1ps
module bipartite_max_matching_top #(
  parameter int MAX_VERTICES = bmm_pkg::DEF_MAX_VERTICES,
  parameter int MAX_EDGES = bmm_pkg::DEF_MAX_EDGES
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [bmm_pkg::CFG_W-1:0] cfg_wdata,
  bmm_req_if.sink                  request,
  bmm_res_if.source                result
);
  import bmm_pkg::*;

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int TW = VW + 1;
  localparam int EW = $clog2(MAX_EDGES);
  localparam int PW = EW + 1;
  localparam int EMW = VTX_W + PW;
  localparam int QW = LAYER_W + VTX_W;
  localparam logic [PW-1:0] NULL_E = PW'(MAX_EDGES);
  localparam logic [CFG_W-1:0] NMAX = CFG_W'(MAX_VERTICES);
  localparam logic [TW-1:0] TMAX = TW'(MAX_VERTICES);
  localparam logic [CFG_W-1:0] PHASE_END = CFG_W'(MAX_VERTICES + 1);

  localparam logic [4:0] S_IDLE = 5'd0, S_ADD = 5'd1, S_PHASE = 5'd2, S_BFS_INIT = 5'd3,
    S_B_POP = 5'd4, S_B_U = 5'd5, S_B_H = 5'd6, S_B_E = 5'd7, S_B_V = 5'd8, S_B_W = 5'd9,
    S_D_ROOT = 5'd10, S_D_RH = 5'd11, S_D_E = 5'd12, S_D_POP = 5'd13, S_D_POPL = 5'd14,
    S_D_V = 5'd15, S_D_C = 5'd16, S_A_RD = 5'd17, S_A_T = 5'd18, S_A_W = 5'd19,
    S_O_RD = 5'd20, S_O_SET = 5'd21;

  logic [4:0] state;
  logic [CFG_W-1:0] num_vertices, n;
  logic [VTX_W-1:0] lv_r, rv_r, cu, vv, su;
  logic add_ok, drop, hrv, limit_set;
  logic [PW-1:0] ec, ce, elink;
  logic [MAX_VERTICES-1:0] hv, lmatch, rmatch, rlv, free;
  logic [TW-1:0] qh, qt, top, k;
  logic [LAYER_W-1:0] limit, clay, lu;
  logic [CFG_W-1:0] phase, i, count;

  logic em_we, em_re, hm_we, hm_re, qm_we, qm_re, rl_we, rl_re;
  logic rp_we, rp_re, lp_we, lp_re, sm_we, sm_re;
  logic [EW-1:0] em_waddr, em_raddr;
  logic [EMW-1:0] em_wdata, em_rd;
  logic [VW-1:0] hm_waddr, hm_raddr, qm_waddr, qm_raddr, rl_waddr, rl_raddr;
  logic [VW-1:0] rp_waddr, rp_raddr, lp_waddr, lp_raddr, sm_waddr, sm_raddr;
  logic [PW-1:0] hm_wdata, hm_rd;
  logic [QW-1:0] qm_wdata, qm_rd;
  logic [LAYER_W-1:0] rl_wdata, rl_rd;
  logic [VTX_W-1:0] rp_wdata, rp_rd, lp_wdata, lp_rd;
  logic [EMW-1:0] sm_wdata, sm_rd;

  logic [VTX_W-1:0] em_tgt, qm_v, sm_v;
  logic [PW-1:0] em_link, head, sm_e;
  logic [LAYER_W-1:0] qm_lay;
  logic slot_free, dfs_ok, out_last;

  assign em_tgt = em_rd[EMW-1:PW];
  assign em_link = em_rd[PW-1:0];
  assign sm_v = sm_rd[EMW-1:PW];
  assign sm_e = sm_rd[PW-1:0];
  assign qm_lay = qm_rd[QW-1:VTX_W];
  assign qm_v = qm_rd[VTX_W-1:0];
  assign head = hrv ? hm_rd : NULL_E;
  assign slot_free = !result.valid || result.ready;
  assign request.ready = (state == S_IDLE);
  assign out_last = ((i + 7'd1) == n);
  assign dfs_ok = ({1'b0, vv} < n) && free[vv[VW-1:0]] && rlv[vv[VW-1:0]] &&
                  (rl_rd == clay + 8'd1);

  always_comb begin
    if (num_vertices == '0) begin
      n = 7'd1;
    end else if (num_vertices > NMAX) begin
      n = NMAX;
    end else begin
      n = num_vertices;
    end
  end

  always_comb begin
    em_we = 1'b0; em_waddr = ec[EW-1:0]; em_wdata = {rv_r, head};
    em_re = 1'b0; em_raddr = ce[EW-1:0];
    hm_we = 1'b0; hm_waddr = lv_r[VW-1:0]; hm_wdata = ec;
    hm_re = 1'b0; hm_raddr = request.left_vertex[VW-1:0];
    qm_we = 1'b0; qm_waddr = qt[VW-1:0]; qm_wdata = {8'd0, i[VTX_W-1:0]};
    qm_re = 1'b0; qm_raddr = qh[VW-1:0];
    rl_we = 1'b0; rl_waddr = em_tgt[VW-1:0]; rl_wdata = lu + 8'd1;
    rl_re = 1'b0; rl_raddr = em_tgt[VW-1:0];
    rp_we = 1'b0; rp_waddr = vv[VW-1:0]; rp_wdata = cu;
    rp_re = 1'b0; rp_raddr = em_tgt[VW-1:0];
    lp_we = 1'b0; lp_waddr = cu[VW-1:0]; lp_wdata = vv;
    lp_re = 1'b0; lp_raddr = i[VW-1:0];
    sm_we = 1'b0; sm_waddr = top[VW-1:0]; sm_wdata = {cu, ce};
    sm_re = 1'b0; sm_raddr = top[VW-1:0] - 1'b1;
    unique case (state)
      S_IDLE: hm_re = request.valid && (request.req_type == REQ_ADD);
      S_ADD: begin
        em_we = add_ok;
        hm_we = add_ok;
      end
      S_BFS_INIT: qm_we = (i != n) && !lmatch[i[VW-1:0]];
      S_B_POP: qm_re = (qh != qt);
      S_B_U: begin
        hm_re = 1'b1;
        hm_raddr = qm_v[VW-1:0];
      end
      S_B_E: em_re = (ce != NULL_E);
      S_B_V: begin
        rl_we = ({1'b0, em_tgt} < n) && !rlv[em_tgt[VW-1:0]];
        rp_re = rl_we && rmatch[em_tgt[VW-1:0]];
      end
      S_B_W: begin
        qm_we = ({1'b0, rp_rd} < n);
        qm_wdata = {lu + 8'd2, rp_rd};
      end
      S_D_ROOT: begin
        hm_re = (i != n) && !lmatch[i[VW-1:0]];
        hm_raddr = i[VW-1:0];
      end
      S_D_E: begin
        em_re = (ce != NULL_E);
        sm_re = (ce == NULL_E) && (top != '0);
      end
      S_D_POP: begin
        em_re = 1'b1;
        em_raddr = sm_e[EW-1:0];
      end
      S_D_V: begin
        rl_re = 1'b1;
        rp_re = 1'b1;
      end
      S_D_C: begin
        if (dfs_ok) begin
          if (!rmatch[vv[VW-1:0]]) begin
            lp_we = 1'b1;
            rp_we = 1'b1;
          end else if (({1'b0, rp_rd} < n) && (top < TMAX)) begin
            sm_we = 1'b1;
            hm_re = 1'b1;
            hm_raddr = rp_rd[VW-1:0];
          end
        end
      end
      S_A_RD: begin
        sm_re = (k != '0);
        sm_raddr = k[VW-1:0] - 1'b1;
      end
      S_A_T: begin
        em_re = 1'b1;
        em_raddr = sm_e[EW-1:0];
      end
      S_A_W: begin
        lp_we = 1'b1;
        lp_waddr = su[VW-1:0];
        lp_wdata = em_tgt;
        rp_we = 1'b1;
        rp_waddr = em_tgt[VW-1:0];
        rp_wdata = su;
      end
      S_O_RD: lp_re = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (hm_re) begin
      hrv <= hv[hm_raddr];
    end
    if (rst) begin
      state <= S_IDLE;
      num_vertices <= CFG_RESET;
      ec <= '0;
      drop <= 1'b0;
      hv <= '0;
      lmatch <= '0;
      rmatch <= '0;
      rlv <= '0;
      free <= '1;
      result.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        num_vertices <= cfg_wdata;
      end
      if (result.ready && !((state == S_O_SET) && slot_free)) begin
        result.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (request.valid) begin
            if (request.req_type == REQ_ADD) begin
              lv_r <= request.left_vertex;
              rv_r <= request.right_vertex;
              add_ok <= ({1'b0, request.left_vertex} < n) &&
                        ({1'b0, request.right_vertex} < n) && (ec != NULL_E);
              state <= S_ADD;
            end else begin
              lmatch <= '0;
              rmatch <= '0;
              rlv <= '0;
              free <= '1;
              phase <= '0;
              count <= '0;
              state <= S_PHASE;
            end
          end
        end
        S_ADD: begin
          if (add_ok) begin
            hv[lv_r[VW-1:0]] <= 1'b1;
            ec <= ec + 1'b1;
          end else begin
            drop <= 1'b1;
          end
          state <= S_IDLE;
        end
        S_PHASE: begin
          i <= '0;
          qh <= '0;
          qt <= '0;
          limit_set <= 1'b0;
          state <= (phase == PHASE_END) ? S_O_RD : S_BFS_INIT;
        end
        S_BFS_INIT: begin
          if (i == n) begin
            state <= S_B_POP;
          end else begin
            if (!lmatch[i[VW-1:0]]) begin
              qt <= qt + 1'b1;
            end
            i <= i + 7'd1;
          end
        end
        S_B_POP: begin
          if (qh == qt) begin
            i <= '0;
            state <= limit_set ? S_D_ROOT : S_O_RD;
          end else begin
            qh <= qh + 1'b1;
            state <= S_B_U;
          end
        end
        S_B_U: begin
          lu <= qm_lay;
          if (limit_set && (qm_lay >= limit)) begin
            i <= '0;
            state <= S_D_ROOT;
          end else begin
            state <= S_B_H;
          end
        end
        S_B_H: begin
          ce <= head;
          state <= S_B_E;
        end
        S_B_E: state <= (ce == NULL_E) ? S_B_POP : S_B_V;
        S_B_V: begin
          elink <= em_link;
          ce <= em_link;
          state <= S_B_E;
          if (rl_we) begin
            rlv[em_tgt[VW-1:0]] <= 1'b1;
            if (!rmatch[em_tgt[VW-1:0]]) begin
              limit <= lu + 8'd1;
              limit_set <= 1'b1;
            end else begin
              state <= S_B_W;
            end
          end
        end
        S_B_W: begin
          if (qm_we) begin
            qt <= qt + 1'b1;
          end
          ce <= elink;
          state <= S_B_E;
        end
        S_D_ROOT: begin
          if (i == n) begin
            rlv <= '0;
            free <= '1;
            phase <= phase + 7'd1;
            state <= S_PHASE;
          end else if (lmatch[i[VW-1:0]]) begin
            i <= i + 7'd1;
          end else begin
            cu <= i[VTX_W-1:0];
            clay <= '0;
            top <= '0;
            state <= S_D_RH;
          end
        end
        S_D_RH: begin
          ce <= head;
          state <= S_D_E;
        end
        S_D_E: begin
          if (ce != NULL_E) begin
            state <= S_D_V;
          end else if (top == '0) begin
            i <= i + 7'd1;
            state <= S_D_ROOT;
          end else begin
            top <= top - 1'b1;
            state <= S_D_POP;
          end
        end
        S_D_POP: begin
          cu <= sm_v;
          clay <= clay - 8'd2;
          state <= S_D_POPL;
        end
        S_D_POPL: begin
          ce <= em_link;
          state <= S_D_E;
        end
        S_D_V: begin
          vv <= em_tgt;
          elink <= em_link;
          state <= S_D_C;
        end
        S_D_C: begin
          ce <= elink;
          state <= S_D_E;
          if (dfs_ok) begin
            free[vv[VW-1:0]] <= 1'b0;
            if (!rmatch[vv[VW-1:0]]) begin
              lmatch[cu[VW-1:0]] <= 1'b1;
              rmatch[vv[VW-1:0]] <= 1'b1;
              k <= top;
              state <= S_A_RD;
            end else if (sm_we) begin
              top <= top + 1'b1;
              cu <= rp_rd;
              clay <= clay + 8'd2;
              state <= S_D_RH;
            end
          end
        end
        S_A_RD: begin
          if (k == '0) begin
            count <= count + 7'd1;
            i <= i + 7'd1;
            state <= S_D_ROOT;
          end else begin
            k <= k - 1'b1;
            state <= S_A_T;
          end
        end
        S_A_T: begin
          su <= sm_v;
          state <= S_A_W;
        end
        S_A_W: begin
          lmatch[su[VW-1:0]] <= 1'b1;
          rmatch[em_tgt[VW-1:0]] <= 1'b1;
          state <= S_A_RD;
        end
        S_O_RD: state <= S_O_SET;
        S_O_SET: begin
          if (slot_free) begin
            result.valid <= 1'b1;
            result.left_index <= i[VTX_W-1:0];
            result.partner <= lmatch[i[VW-1:0]] ? {1'b0, lp_rd} : UNMATCHED;
            result.match_count <= out_last ? count : '0;
            result.edges_dropped <= drop;
            result.last <= out_last;
            i <= i + 7'd1;
            state <= out_last ? S_IDLE : S_O_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  bmm_ram #(.DEPTH(MAX_EDGES), .WIDTH(EMW)) u_edge_ram (
    .clk(clk), .we(em_we), .waddr(em_waddr), .wdata(em_wdata),
    .re(em_re), .raddr(em_raddr), .rdata(em_rd));
  bmm_ram #(.DEPTH(MAX_VERTICES), .WIDTH(PW)) u_head_ram (
    .clk(clk), .we(hm_we), .waddr(hm_waddr), .wdata(hm_wdata),
    .re(hm_re), .raddr(hm_raddr), .rdata(hm_rd));
  bmm_ram #(.DEPTH(MAX_VERTICES), .WIDTH(QW)) u_queue_ram (
    .clk(clk), .we(qm_we), .waddr(qm_waddr), .wdata(qm_wdata),
    .re(qm_re), .raddr(qm_raddr), .rdata(qm_rd));
  bmm_ram #(.DEPTH(MAX_VERTICES), .WIDTH(LAYER_W)) u_rlayer_ram (
    .clk(clk), .we(rl_we), .waddr(rl_waddr), .wdata(rl_wdata),
    .re(rl_re), .raddr(rl_raddr), .rdata(rl_rd));
  bmm_ram #(.DEPTH(MAX_VERTICES), .WIDTH(VTX_W)) u_rpart_ram (
    .clk(clk), .we(rp_we), .waddr(rp_waddr), .wdata(rp_wdata),
    .re(rp_re), .raddr(rp_raddr), .rdata(rp_rd));
  bmm_ram #(.DEPTH(MAX_VERTICES), .WIDTH(VTX_W)) u_lpart_ram (
    .clk(clk), .we(lp_we), .waddr(lp_waddr), .wdata(lp_wdata),
    .re(lp_re), .raddr(lp_raddr), .rdata(lp_rd));
  bmm_ram #(.DEPTH(MAX_VERTICES), .WIDTH(EMW)) u_stack_ram (
    .clk(clk), .we(sm_we), .waddr(sm_waddr), .wdata(sm_wdata),
    .re(sm_re), .raddr(sm_raddr), .rdata(sm_rd));
endmodule

FILE: sv/bmm_ram.sv
// Single-port-write, single-port-read memory with registered read data.
`timescale 1ns / 1ps
module bmm_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

FILE: sv/bmm_checker.sv
// Port-level checker of the matching engine and its bind to the top level.
`timescale 1ns / 1ps
`include "bipartite_max_matching_top_defines.svh"
module bmm_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [bmm_pkg::VTX_W-1:0]  out_left_index,
  input logic [bmm_pkg::PART_W-1:0] out_partner,
  input logic [bmm_pkg::PART_W-1:0] out_match_count,
  input logic                        out_last
);
  import bmm_pkg::*;

  logic [PART_W-1:0] index_count;

  assign index_count = {1'b0, out_left_index} + 7'd1;

  `BMM_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid)
  `BMM_ASSERT_NOW(a_count_last, out_valid && !out_last, out_match_count == '0)
  `BMM_ASSERT_NOW(a_partner_range, out_valid, out_partner <= UNMATCHED)
  `BMM_ASSERT_NOW(a_count_bound, out_valid && out_last, out_match_count <= index_count)
  `BMM_ASSERT_RST(a_reset_idle, rst, !out_valid)
endmodule

bind bipartite_max_matching_top bmm_checker u_bmm_checker (
  .clk(clk), .rst(rst), .out_valid(result.valid), .out_ready(result.ready),
  .out_left_index(result.left_index), .out_partner(result.partner),
  .out_match_count(result.match_count), .out_last(result.last));

FILE: bench/bmm_match_checker.sv
// Checker that predicts the matching engine's results and compares them.
`timescale 1ns / 1ps
module bmm_match_checker
  import bmm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CFG_W-1:0]    cfg_wdata,
  bmm_req_if                  request,
  bmm_res_if                  result,
  output int                  fail_count,
  output int                  results_pending
);
  localparam int NV = DEF_MAX_VERTICES;
  localparam int NE = DEF_MAX_EDGES;
  localparam int FAR_LAYER = 100000;

  typedef struct packed {
    logic [VTX_W-1:0]  left_index;
    logic [PART_W-1:0] partner;
    logic [PART_W-1:0] match_count;
    logic              edges_dropped;
    logic              last;
  } match_row_t;

  match_row_t rows_due[$];

  logic [CFG_W-1:0] vertex_cfg;
  int edge_dest[NE];
  int edge_next[NE];
  int list_first[NV];
  int edges_stored;
  bit any_dropped;
  int left_mate[NV];
  int right_mate[NV];
  int left_depth[NV];
  int right_depth[NV];
  bit right_open[NV];
  int bfs_fifo[NV];
  int dfs_vert[NV+1];
  int dfs_edge[NV+1];

  function automatic int vertices_in_use();
    int n;
    n = int'(vertex_cfg);
    if (n == 0) n = 1;
    if (n > NV) n = NV;
    return n;
  endfunction

  function automatic void reset_layers(int n);
    for (int i = 0; i < n; i++) begin
      left_depth[i] = -1;
      right_depth[i] = -1;
      right_open[i] = 1'b1;
    end
  endfunction

  function automatic bit build_layers(int n);
    int limit, qh, qt, u, e, v, w;
    limit = FAR_LAYER;
    qh = 0;
    qt = 0;
    for (int i = 0; i < n; i++) begin
      if (left_mate[i] == UNMATCHED && qt < NV) begin
        bfs_fifo[qt] = i;
        qt++;
        left_depth[i] = 0;
      end
    end
    while (qh < qt) begin
      u = bfs_fifo[qh];
      qh++;
      if (left_depth[u] >= limit) break;
      e = list_first[u];
      while (e < NE) begin
        v = edge_dest[e];
        if (v < n && right_depth[v] == -1) begin
          right_depth[v] = left_depth[u] + 1;
          w = right_mate[v];
          if (w == UNMATCHED) begin
            limit = right_depth[v];
          end else if (w < n && qt < NV) begin
            left_depth[w] = right_depth[v] + 1;
            bfs_fifo[qt] = w;
            qt++;
          end
        end
        e = edge_next[e];
      end
    end
    return limit != FAR_LAYER;
  endfunction

  function automatic bit augment_path(int root, int n);
    int top, u, e, v, w, k;
    top = 0;
    dfs_vert[0] = root;
    dfs_edge[0] = list_first[root];
    forever begin
      u = dfs_vert[top];
      e = dfs_edge[top];
      if (e >= NE) begin
        if (top == 0) return 1'b0;
        top--;
        dfs_edge[top] = edge_next[dfs_edge[top]];
        continue;
      end
      v = edge_dest[e];
      if (v < n && right_open[v] && right_depth[v] == left_depth[u] + 1) begin
        right_open[v] = 1'b0;
        w = right_mate[v];
        if (w == UNMATCHED) begin
          k = top + 1;
          while (k > 0) begin
            k--;
            u = dfs_vert[k];
            v = edge_dest[dfs_edge[k]];
            left_mate[u] = v;
            right_mate[v] = u;
          end
          return 1'b1;
        end
        if (w < n && top < NV) begin
          top++;
          dfs_vert[top] = w;
          dfs_edge[top] = list_first[w];
          continue;
        end
      end
      dfs_edge[top] = edge_next[e];
    end
  endfunction

  function automatic void predict_matching();
    int n, matched;
    match_row_t row;
    n = vertices_in_use();
    matched = 0;
    for (int i = 0; i < NV; i++) begin
      left_mate[i] = UNMATCHED;
      right_mate[i] = UNMATCHED;
    end
    reset_layers(NV);
    for (int phase = 0; phase <= NV; phase++) begin
      if (!build_layers(n)) break;
      for (int i = 0; i < n; i++)
        if (left_mate[i] == UNMATCHED && augment_path(i, n)) matched++;
      reset_layers(n);
    end
    for (int i = 0; i < n; i++) begin
      row.left_index = i[VTX_W-1:0];
      row.partner = left_mate[i][PART_W-1:0];
      row.match_count = (i + 1 == n) ? matched[PART_W-1:0] : '0;
      row.edges_dropped = any_dropped;
      row.last = (i + 1 == n);
      rows_due = {rows_due, row};
    end
  endfunction

  function automatic void store_edge(int lv, int rv);
    int n;
    n = vertices_in_use();
    if (lv >= n || rv >= n || edges_stored >= NE) begin
      any_dropped = 1'b1;
    end else begin
      edge_dest[edges_stored] = rv;
      edge_next[edges_stored] = list_first[lv];
      list_first[lv] = edges_stored;
      edges_stored++;
    end
  endfunction

  always @(posedge clk) begin
    match_row_t got, want;
    if (rst) begin
      vertex_cfg = CFG_RESET;
      for (int i = 0; i < NV; i++) list_first[i] = NE;
      edges_stored = 0;
      any_dropped = 1'b0;
      rows_due.delete();
      fail_count = 0;
    end else begin
      if (result.valid && result.ready) begin
        got = '{result.left_index, result.partner, result.match_count,
                result.edges_dropped, result.last};
        if (rows_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("Unexpected result item: %p", got);
        end else begin
          want = rows_due.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) $display("Result mismatch: expected %p, got %p", want, got);
          end
        end
      end
      if (request.valid && request.ready) begin
        if (request.req_type == REQ_RUN) predict_matching();
        else store_edge(int'(request.left_vertex), int'(request.right_vertex));
      end
      if (cfg_we) vertex_cfg = cfg_wdata;
    end
    results_pending = rows_due.size();
  end
endmodule

FILE: bench/tb.sv
// Testbench top: drives edges, run requests and vertex counts into the matching engine.
`timescale 1ns / 1ps
module tb;
  import bmm_pkg::*;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  bit steady;
  int fail_count;
  int results_pending;
  int edges_sent;
  int runs_sent;
  int sizes[8] = '{4, 3, 6, 8, 5, 12, 2, 7};

  bmm_req_if request();
  bmm_res_if result();

  bipartite_max_matching_top uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .request(request), .result(result)
  );

  bmm_match_checker checker_i (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .request(request), .result(result),
    .fail_count(fail_count), .results_pending(results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("tb NOT OK");
    $finish;
  end

  always @(negedge clk) begin
    if (rst) result.ready <= 1'b0;
    else result.ready <= steady || ($urandom_range(99) >= 31);
  end

  task automatic send(input logic kind, input int lv, input int rv);
    while (!steady && $urandom_range(99) < 31) begin
      request.valid <= 1'b0;
      @(negedge clk);
    end
    request.valid <= 1'b1;
    request.req_type <= kind;
    request.left_vertex <= lv[VTX_W-1:0];
    request.right_vertex <= rv[VTX_W-1:0];
    do @(posedge clk); while (!request.ready);
    @(negedge clk);
    if (kind == REQ_RUN) runs_sent++;
    else edges_sent++;
  endtask

  task automatic drain();
    request.valid <= 1'b0;
    do @(negedge clk); while (results_pending != 0);
    repeat (10) @(negedge clk);
  endtask

  task automatic set_vertices(input int value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value[CFG_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int n;
    int count;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    request.valid = 1'b0;
    request.req_type = REQ_ADD;
    request.left_vertex = '0;
    request.right_vertex = '0;
    edges_sent = 0;
    runs_sent = 0;
    steady = 1'b0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    send(REQ_RUN, 0, 0);
    send(REQ_ADD, 0, 0);
    send(REQ_ADD, 63, 63);
    send(REQ_ADD, 0, 63);
    send(REQ_ADD, 1, 0);
    send(REQ_RUN, 0, 0);
    set_vertices(2);
    send(REQ_ADD, 0, 1);
    send(REQ_ADD, 2, 0);
    send(REQ_ADD, 0, 2);
    send(REQ_RUN, 0, 0);
    set_vertices(0);
    send(REQ_RUN, 0, 0);
    set_vertices(1);
    send(REQ_RUN, 0, 0);
    set_vertices(127);
    send(REQ_ADD, 62, 62);
    send(REQ_RUN, 0, 0);

    for (int seg = 0; seg < 12; seg++) begin
      steady = (seg >= 5 && seg < 8);
      n = sizes[seg % 8];
      set_vertices(n);
      count = $urandom_range(10, 4);
      for (int k = 0; k < count; k++) begin
        if ($urandom_range(99) < 10) send(REQ_ADD, $urandom_range(63), $urandom_range(63));
        else send(REQ_ADD, $urandom_range(n - 1), $urandom_range(n - 1));
      end
      send(REQ_RUN, 0, 0);
      if (seg == 9) send(REQ_RUN, 0, 0);
    end

    steady = 1'b0;
    set_vertices(64);
    repeat (6) send(REQ_ADD, $urandom_range(63), $urandom_range(63));
    send(REQ_RUN, 0, 0);
    set_vertices(3);
    send(REQ_RUN, 0, 0);

    drain();
    $display("Sent %0d edge items and %0d run requests over vertex counts 0 to 127,",
             edges_sent, runs_sent);
    $display("including dropped edges, repeated runs and shrunk vertex counts.");
    if (fail_count == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end
endmodule
